[sv/edf_ts_pkg.sv]
// shared types, codes and helpers of the edf tick scheduler
`timescale 1ns / 1ps
package edf_ts_pkg;

  localparam logic [2:0] IDLE_CODE = 3'd4;
  localparam int unsigned LANES = 4;

  localparam logic [2:0] REG_COMPUTE  = 3'd0;
  localparam logic [2:0] REG_PERIODS  = 3'd1;
  localparam logic [2:0] REG_DEADLINE = 3'd2;
  localparam logic [2:0] REG_ENABLE   = 3'd3;
  localparam logic [2:0] REG_RUNLEN   = 3'd4;

  // per-task job record held in memory
  typedef struct packed {
    logic [15:0] jobs;
    logic        ready;
    logic [7:0]  owed;
    logic [7:0]  done;
  } ent_t;

  // 8-bit lane of a packed config word; tasks past the lanes read zero
  function automatic logic [7:0] lane_of(input logic [31:0] word, input logic [2:0] idx);
    logic [7:0] r;
    r = 8'd0;
    if (idx < 3'(LANES)) r = word[{idx[1:0], 3'b000} +: 8];
    return r;
  endfunction

endpackage

[sv/edf_tick_scheduler.sv]
// edf tick scheduler top level: config port, task memory and tick sequencer
`timescale 1ns / 1ps
// per tick, each task takes a memory read, a latch step, a 16-step bit-serial modulo
//   of the time by the period, a release/write-back step and a deadline compare step;
//   then the chosen task is updated; past the run end the word comes from the check state
// one tick at a time: a new tick is taken only in idle, also while a result waits
// reset (rst, synchronous): clears config to its defaults, time, task valid bits
//   and previous-task state; restart on a word clears the same job state
module edf_tick_scheduler #(
  parameter int MAX_TASKS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        restart,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  running_task,
  output logic        overdue_unit,
  output logic        job_finished,
  output logic        preempted,
  output logic [15:0] tick_time,
  output logic        run_done,
  // apb config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] LAST = CW'(MAX_TASKS - 1);

  typedef enum logic [2:0] {S_IDLE, S_CHK, S_READ, S_LAT, S_MOD, S_REL, S_KEY, S_UPD} state_t;

  // config registers
  logic [31:0] compute_times, periods, deadlines;
  logic [3:0]  task_enable;
  logic [15:0] run_length;

  // sequencer state
  state_t                 state;
  logic [15:0]            cur_time;
  logic [2:0]             prev_task;
  logic                   prev_ended;
  logic [MAX_TASKS-1:0]   vld;
  logic [CW-1:0]          ti;
  logic [3:0]             bitc;
  logic [7:0]             rem;
  edf_ts_pkg::ent_t       ent;
  logic [23:0]            prod;

  // selection
  logic                   sel_valid, sel_over;
  logic [2:0]             sel_id;
  logic signed [26:0]     best;
  edf_ts_pkg::ent_t       sel_ent;

  // task memory
  logic [$bits(edf_ts_pkg::ent_t)-1:0] mem [MAX_TASKS];
  logic [$bits(edf_ts_pkg::ent_t)-1:0] rd_data;
  logic                   wr_en;
  logic [TW-1:0]          wr_addr;
  edf_ts_pkg::ent_t       wr_data;

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[4:2])
      edf_ts_pkg::REG_COMPUTE:  prdata = compute_times;
      edf_ts_pkg::REG_PERIODS:  prdata = periods;
      edf_ts_pkg::REG_DEADLINE: prdata = deadlines;
      edf_ts_pkg::REG_ENABLE:   prdata = {28'd0, task_enable};
      edf_ts_pkg::REG_RUNLEN:   prdata = {16'd0, run_length};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compute_times <= '0;
      periods       <= '0;
      deadlines     <= '0;
      task_enable   <= '0;
      run_length    <= 16'd1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        edf_ts_pkg::REG_COMPUTE:  compute_times <= pwdata;
        edf_ts_pkg::REG_PERIODS:  periods       <= pwdata;
        edf_ts_pkg::REG_DEADLINE: deadlines     <= pwdata;
        edf_ts_pkg::REG_ENABLE:   task_enable   <= pwdata[3:0];
        edf_ts_pkg::REG_RUNLEN:   run_length    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // current task's lanes
  logic [2:0] tid;
  logic [7:0] c_lane, p_lane, d_lane;
  logic       t_en;
  assign tid    = 3'(ti);
  assign c_lane = edf_ts_pkg::lane_of(compute_times, tid);
  assign p_lane = edf_ts_pkg::lane_of(periods, tid);
  assign d_lane = edf_ts_pkg::lane_of(deadlines, tid);
  assign t_en   = (tid < 3'(edf_ts_pkg::LANES)) && task_enable[tid[1:0]];

  // bit-serial modulo step
  logic [8:0] rem_sh;
  assign rem_sh = {rem, cur_time[bitc]};

  // release of the current task
  logic             rel;
  edf_ts_pkg::ent_t ent_rel;
  always_comb begin
    rel = (cur_time == 16'd0) ||
          (p_lane != 8'd0 && cur_time >= {8'd0, p_lane} && rem == 8'd0);
    ent_rel = ent;
    if (t_en && rel) begin
      if (ent.ready) ent_rel.owed = (c_lane > ent.done) ? c_lane - ent.done : 8'd0;
      ent_rel.done  = 8'd0;
      ent_rel.ready = 1'b1;
    end
  end

  // deadline key: deadline + period*jobs - time, signed
  logic signed [26:0] key;
  logic               elig, elig_over;
  assign key = $signed({19'd0, d_lane}) + $signed({3'd0, prod}) - $signed({11'd0, cur_time});
  assign elig      = t_en && ent.ready;
  assign elig_over = elig && (ent.owed != 8'd0);

  // unit update of the chosen task
  edf_ts_pkg::ent_t upd_ent;
  logic             upd_fin;
  logic [7:0]       sel_c;
  logic [8:0]       d_inc;
  always_comb begin
    sel_c   = edf_ts_pkg::lane_of(compute_times, sel_id);
    d_inc   = {1'b0, sel_ent.done} + 9'd1;
    upd_ent = sel_ent;
    upd_fin = 1'b0;
    if (sel_over) begin
      upd_ent.owed = sel_ent.owed - 8'd1;
      upd_fin      = (sel_ent.owed == 8'd1);
    end else if (d_inc >= {1'b0, sel_c}) begin
      upd_fin       = 1'b1;
      upd_ent.done  = 8'd0;
      upd_ent.ready = 1'b0;
      upd_ent.jobs  = sel_ent.jobs + 16'd1;
    end else begin
      upd_ent.done = d_inc[7:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // memory write port: release write-back or unit update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ti[TW-1:0];
    wr_data = ent_rel;
    if (state == S_REL && t_en && rel) wr_en = 1'b1;
    if (state == S_UPD && out_free && sel_valid) begin
      wr_en   = 1'b1;
      wr_addr = sel_id[TW-1:0];
      wr_data = upd_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[ti[TW-1:0]];
  end

  // tick sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_time   <= '0;
      prev_task  <= edf_ts_pkg::IDLE_CODE;
      prev_ended <= 1'b1;
      vld        <= '0;
      out_valid  <= 1'b0;
      ti         <= '0;
      sel_valid  <= 1'b0;
      sel_over   <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (restart) begin
              cur_time   <= '0;
              prev_task  <= edf_ts_pkg::IDLE_CODE;
              prev_ended <= 1'b1;
              vld        <= '0;
            end
            state <= S_CHK;
          end
        end
        S_CHK: begin
          ti        <= '0;
          sel_valid <= 1'b0;
          sel_over  <= 1'b0;
          if (cur_time >= run_length) begin
            // run over: report only, no state change
            if (out_free) begin
              out_valid    <= 1'b1;
              running_task <= edf_ts_pkg::IDLE_CODE;
              overdue_unit <= 1'b0;
              job_finished <= 1'b0;
              preempted    <= 1'b0;
              tick_time    <= (cur_time == 16'hFFFF) ? 16'hFFFF : cur_time + 16'd1;
              run_done     <= 1'b1;
              state        <= S_IDLE;
            end
          end else begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_LAT;
        S_LAT: begin
          ent   <= vld[ti[TW-1:0]] ? edf_ts_pkg::ent_t'(rd_data) : '0;
          rem   <= 8'd0;
          bitc  <= 4'd15;
          state <= S_MOD;
        end
        S_MOD: begin
          rem  <= (rem_sh >= {1'b0, p_lane}) ? 8'(rem_sh - {1'b0, p_lane}) : rem_sh[7:0];
          bitc <= bitc - 4'd1;
          if (bitc == 4'd0) state <= S_REL;
        end
        S_REL: begin
          ent  <= ent_rel;
          prod <= {16'd0, p_lane} * {8'd0, ent_rel.jobs};
          if (t_en && rel) vld[ti[TW-1:0]] <= 1'b1;
          state <= S_KEY;
        end
        S_KEY: begin
          // overdue wins at lowest id, else nearest deadline, ties to lowest id
          if (!sel_over) begin
            if (elig_over) begin
              sel_valid <= 1'b1;
              sel_over  <= 1'b1;
              sel_id    <= tid;
              sel_ent   <= ent;
            end else if (elig && (!sel_valid || key < best)) begin
              sel_valid <= 1'b1;
              sel_id    <= tid;
              best      <= key;
              sel_ent   <= ent;
            end
          end
          if (ti == LAST) begin
            state <= S_UPD;
          end else begin
            ti    <= ti + CW'(1);
            state <= S_READ;
          end
        end
        S_UPD: begin
          if (out_free) begin
            cur_time     <= cur_time + 16'd1;
            out_valid    <= 1'b1;
            tick_time    <= cur_time + 16'd1;
            run_done     <= 1'b0;
            if (sel_valid) begin
              running_task <= sel_id;
              overdue_unit <= sel_over;
              job_finished <= upd_fin;
              preempted    <= (sel_id != prev_task) && !prev_ended &&
                              (prev_task != edf_ts_pkg::IDLE_CODE);
              prev_task    <= sel_id;
              prev_ended   <= upd_fin;
            end else begin
              running_task <= edf_ts_pkg::IDLE_CODE;
              overdue_unit <= 1'b0;
              job_finished <= 1'b0;
              preempted    <= 1'b0;
              prev_task    <= edf_ts_pkg::IDLE_CODE;
              prev_ended   <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/edf_ts_checker.sv]
// port-level checks of the edf tick scheduler and their bind
`timescale 1ns / 1ps
module edf_ts_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] running_task,
  input logic       overdue_unit,
  input logic       job_finished,
  input logic       preempted,
  input logic       run_done
);

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_done |-> running_task == edf_ts_pkg::IDLE_CODE &&
      !overdue_unit && !job_finished && !preempted)
    else $error("run over word carries a task or flags");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && running_task == edf_ts_pkg::IDLE_CODE |->
      !overdue_unit && !job_finished && !preempted)
    else $error("idle word carries flags");

  a_task_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> running_task <= edf_ts_pkg::IDLE_CODE)
    else $error("task code out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(running_task) && $stable(run_done))
    else $error("stalled word changed");

endmodule

bind edf_tick_scheduler edf_ts_checker u_edf_ts_checker (.*);

[tb/tb_edf_tick_scheduler.sv]
// self-checking testbench of the edf tick scheduler
`timescale 1ns / 1ps
module tb_edf_tick_scheduler;

  localparam int NTASK = 4;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  running_task;
  logic        overdue_unit;
  logic        job_finished;
  logic        preempted;
  logic [15:0] tick_time;
  logic        run_done;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  edf_tick_scheduler #(.MAX_TASKS(NTASK)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one expected result word
  typedef struct packed {
    logic [2:0]  task_id;
    logic        overdue;
    logic        finished;
    logic        preempt;
    logic [15:0] now;
    logic        done;
  } tick_res_t;

  // shadow of the configuration
  logic [31:0] sh_compute, sh_period, sh_deadline;
  logic [3:0]  sh_enable;
  logic [15:0] sh_runlen;

  // shadow of the job state
  logic [15:0] sh_time;
  logic [7:0]  sh_done [NTASK];
  logic [7:0]  sh_owed [NTASK];
  logic        sh_ready [NTASK];
  logic [15:0] sh_jobs [NTASK];
  logic [2:0]  sh_prev;
  logic        sh_prev_ended;

  tick_res_t expected_ticks[$];
  int mismatches = 0;
  int ticks_seen = 0;
  int done_seen = 0;
  int preempt_seen = 0;
  int overdue_seen = 0;
  int idle_cycles = 0;

  logic hold_off = 1'b0;

  function automatic logic [7:0] lane(input logic [31:0] w, input int i);
    return w[8*i +: 8];
  endfunction

  function automatic void clear_job_state();
    sh_time = '0;
    for (int i = 0; i < NTASK; i++) begin
      sh_done[i] = '0;
      sh_owed[i] = '0;
      sh_ready[i] = 1'b0;
      sh_jobs[i] = '0;
    end
    sh_prev = edf_ts_pkg::IDLE_CODE;
    sh_prev_ended = 1'b1;
  endfunction

  // edf step: releases, selection, bookkeeping
  function automatic tick_res_t schedule_tick(input logic rs);
    tick_res_t r;
    logic [2:0] run;
    logic ovd, fin, pre;
    longint best, rem;
    logic [7:0] p, c;
    logic [8:0] d;
    r = '0;
    run = edf_ts_pkg::IDLE_CODE;
    ovd = 1'b0;
    fin = 1'b0;
    pre = 1'b0;
    best = 0;
    if (rs) clear_job_state();
    if (sh_time >= sh_runlen) begin
      r.task_id = edf_ts_pkg::IDLE_CODE;
      r.now = (sh_time == 16'hFFFF) ? 16'hFFFF : sh_time + 16'd1;
      r.done = 1'b1;
      return r;
    end
    for (int i = 0; i < NTASK; i++) begin
      p = lane(sh_period, i);
      if (!sh_enable[i]) continue;
      if (sh_time == 0 || (p != 0 && sh_time >= p && (sh_time % p) == 0)) begin
        if (sh_ready[i]) begin
          c = lane(sh_compute, i);
          sh_owed[i] = (c > sh_done[i]) ? c - sh_done[i] : 8'd0;
        end
        sh_done[i] = '0;
        sh_ready[i] = 1'b1;
      end
    end
    // overdue work goes first, lowest id wins
    for (int i = 0; i < NTASK; i++) begin
      if (sh_enable[i] && sh_ready[i] && sh_owed[i] != 0) begin
        run = 3'(i);
        ovd = 1'b1;
        break;
      end
    end
    if (!ovd) begin
      for (int i = 0; i < NTASK; i++) begin
        if (!sh_enable[i] || !sh_ready[i]) continue;
        rem = longint'(lane(sh_deadline, i)) + longint'(lane(sh_period, i)) *
              longint'(sh_jobs[i]) - longint'(sh_time);
        if (run == edf_ts_pkg::IDLE_CODE || rem < best) begin
          run = 3'(i);
          best = rem;
        end
      end
    end
    sh_time = sh_time + 16'd1;
    if (run != edf_ts_pkg::IDLE_CODE) begin
      if (ovd) begin
        sh_owed[run] = sh_owed[run] - 8'd1;
        fin = (sh_owed[run] == 0);
      end else begin
        d = {1'b0, sh_done[run]} + 9'd1;
        if (d >= {1'b0, lane(sh_compute, run)}) begin
          fin = 1'b1;
          sh_done[run] = '0;
          sh_ready[run] = 1'b0;
          sh_jobs[run] = sh_jobs[run] + 16'd1;
        end else begin
          sh_done[run] = d[7:0];
        end
      end
      pre = (run != sh_prev) && !sh_prev_ended && (sh_prev != edf_ts_pkg::IDLE_CODE);
      sh_prev = run;
      sh_prev_ended = fin;
    end else begin
      sh_prev = edf_ts_pkg::IDLE_CODE;
      sh_prev_ended = 1'b0;
    end
    r.task_id = run;
    r.overdue = ovd;
    r.finished = fin;
    r.preempt = pre;
    r.now = sh_time;
    r.done = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tick %0d: %s got %0d want %0d", ticks_seen, what, got, want);
    mismatches++;
  endtask

  // apb write: setup cycle, access cycle, then the bus goes idle
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      edf_ts_pkg::REG_COMPUTE:  sh_compute = val;
      edf_ts_pkg::REG_PERIODS:  sh_period = val;
      edf_ts_pkg::REG_DEADLINE: sh_deadline = val;
      edf_ts_pkg::REG_ENABLE:   sh_enable = val[3:0];
      edf_ts_pkg::REG_RUNLEN:   sh_runlen = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_task_set(input logic [31:0] c, input logic [31:0] p,
                               input logic [31:0] d, input logic [3:0] en,
                               input logic [15:0] rl);
    reg_write(edf_ts_pkg::REG_COMPUTE, c);
    reg_write(edf_ts_pkg::REG_PERIODS, p);
    reg_write(edf_ts_pkg::REG_DEADLINE, d);
    reg_write(edf_ts_pkg::REG_ENABLE, {28'd0, en});
    reg_write(edf_ts_pkg::REG_RUNLEN, {16'd0, rl});
  endtask

  // send one tick word, after a random gap; valid stays up into a back-to-back word
  task automatic send_tick(input logic rs, input int gap_max);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_ticks.push_back(schedule_tick(rs));
  endtask

  // drop valid, wait until every expected word came back, then settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // receiver: random stall per word, plus a long hold-off when asked
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0 || hold_off) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // checker: compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    tick_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        e = expected_ticks.pop_front();
        if (running_task !== e.task_id) report_mismatch("running_task", running_task, e.task_id);
        if (overdue_unit !== e.overdue) report_mismatch("overdue_unit", overdue_unit, e.overdue);
        if (job_finished !== e.finished) report_mismatch("job_finished", job_finished, e.finished);
        if (preempted !== e.preempt) report_mismatch("preempted", preempted, e.preempt);
        if (tick_time !== e.now) report_mismatch("tick_time", tick_time, e.now);
        if (run_done !== e.done) report_mismatch("run_done", run_done, e.done);
        if (e.done) done_seen++;
        if (e.preempt) preempt_seen++;
        if (e.overdue) overdue_seen++;
      end
      ticks_seen++;
    end
  end

  // watchdog on cycles with no handshake and no bus access at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("Mismatches found");
      $finish;
    end
  end

  // directed rows: restart flag and the word expected, where it is obvious
  typedef struct {
    logic      rs;
    logic      known;
    tick_res_t want;
  } row_t;

  initial begin
    row_t rows[$];
    tick_res_t got;
    int nsets;
    logic [31:0] c, p, d;
    sh_compute = '0;
    sh_period = '0;
    sh_deadline = '0;
    sh_enable = '0;
    sh_runlen = 16'd1;
    clear_job_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset: nothing enabled, run length one
    rows.push_back('{1'b0, 1'b1, '{edf_ts_pkg::IDLE_CODE, 1'b0, 1'b0, 1'b0, 16'd1, 1'b0}});
    rows.push_back('{1'b0, 1'b1, '{edf_ts_pkg::IDLE_CODE, 1'b0, 1'b0, 1'b0, 16'd2, 1'b1}});
    rows.push_back('{1'b1, 1'b1, '{edf_ts_pkg::IDLE_CODE, 1'b0, 1'b0, 1'b0, 16'd1, 1'b0}});
    foreach (rows[k]) begin
      got = schedule_tick(rows[k].rs);
      if (rows[k].known && got !== rows[k].want) begin
        $display("directed row %0d disagrees with typed value", k);
        mismatches++;
      end
      // queue the result; queue and shadow are reset below and send_tick recomputes
      expected_ticks.push_back(got);
    end
    // re-run through the block: the shadow already advanced, so restart it
    expected_ticks.delete();
    clear_job_state();
    foreach (rows[k]) send_tick(rows[k].rs, 2);
    drain();

    // zero run length ends at once
    reg_write(edf_ts_pkg::REG_RUNLEN, 32'd0);
    send_tick(1'b1, 0);
    send_tick(1'b0, 0);
    drain();

    // overload: overdue, zero compute, zero period, preemption
    load_task_set(32'h00_03_00_05, 32'h00_00_06_04, 32'h00_02_06_03, 4'hF, 16'd20);
    for (int k = 0; k < 22; k++) send_tick(k == 0, 3);
    drain();

    // extremes of the lanes
    load_task_set(32'hFF_FF_FF_FF, 32'hFF_FF_FF_FF, 32'hFF_00_FF_00, 4'hF, 16'hFFFF);
    for (int k = 0; k < 6; k++) send_tick(k == 0, 1);
    drain();

    // pressure: hold the receiver off while ticks keep coming
    hold_off = 1'b1;
    fork
      begin
        for (int k = 0; k < 10; k++) send_tick(1'b0, 0);
      end
      begin
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain();

    // random task sets, mostly short runs from restart with a few stray restarts
    nsets = 0;
    while (ticks_seen < 850) begin
      c = {8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
           8'($urandom_range(0, 4)), 8'($urandom_range(0, 4))};
      p = {8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
           8'($urandom_range(0, 12)), 8'($urandom_range(0, 12))};
      d = {8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
           8'($urandom_range(0, 15)), 8'($urandom_range(0, 15))};
      if ($urandom_range(0, 9) == 0) begin
        c = $urandom;
        p = $urandom;
        d = $urandom;
      end
      load_task_set(c, p, d, 4'($urandom), 16'($urandom_range(0, 40)));
      for (int k = 0; k < 45; k++)
        send_tick(k == 0 || $urandom_range(0, 60) == 0, ($urandom_range(0, 4) == 0) ? 0 : 12);
      drain();
      nsets++;
    end
    // touch the upper bits of run length once
    reg_write(edf_ts_pkg::REG_RUNLEN, 32'h0000_8001);
    send_tick(1'b1, 0);
    drain();

    $display("%0d ticks in all, %0d random task sets; %0d overdue units, %0d preemptions,",
             ticks_seen, nsets, overdue_seen, preempt_seen);
    $display("%0d ticks past the end of a run", done_seen);
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/edf_ts_pkg.sv
sv/edf_tick_scheduler.sv
sv/edf_ts_checker.sv
tb/tb_edf_tick_scheduler.sv
